// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands on clk, with and without the rst qualifier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BFDH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define BFDH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bfdh_pkg.sv =====
// ----------------------------------------------------------------------------
// bfdh_pkg
// shared constants and types of the bloom filter block
// ----------------------------------------------------------------------------
package bfdh_pkg;

  localparam logic [63:0] OFFSET_ONE = 64'hcbf29ce484222325;
  localparam logic [63:0] OFFSET_TWO = 64'h9e3779b97f4a7c15 ^ 64'h84222325cbf29ce4;
  localparam logic [63:0] MIX_MUL    = 64'hff51afd7ed558ccd;
  localparam int          MIX_SHIFT  = 33;
  localparam int          WORD_BITS  = 64;
  localparam int          JOB_QUEUE_DEPTH = 2;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_RESULT
  } back_state_t;

endpackage

// ===== src/bfdh_ram.sv =====
// ----------------------------------------------------------------------------
// bfdh_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module bfdh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bfdh_queue.sv =====
// ----------------------------------------------------------------------------
// bfdh_queue
// short fifo carrying probe jobs from the hash front to the probe back
// ----------------------------------------------------------------------------
module bfdh_queue import bfdh_pkg::*; #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output q_status_t        status
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CntW-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  assign rdata        = mem[rptr];
  assign status.full  = (count == CntW'(DEPTH));
  assign status.empty = (count == '0);

endmodule

// ===== src/bfdh_front.sv =====
// ----------------------------------------------------------------------------
// bfdh_front
// byte intake, running fnv-1a hashes and key-end finalization into probe jobs
// ----------------------------------------------------------------------------
module bfdh_front import bfdh_pkg::*; #(
  parameter int FILTER_BITS = 256
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  output logic                                     full,
  input  logic                                     mode,
  input  logic [7:0]                               key_byte,
  input  logic                                     key_last,
  input  logic                                     empty_key,
  input  q_status_t                                q_status,
  output logic                                     job_push,
  output logic [2*$clog2(FILTER_BITS):0]           job_data
);

  localparam int L   = $clog2(FILTER_BITS);
  localparam int HW1 = MIX_SHIFT + L;

  localparam logic [HW1-1:0] Off1  = HW1'(OFFSET_ONE);
  localparam logic [L-1:0]   Off2  = L'(OFFSET_TWO);
  localparam logic [L-1:0]   MixLo = L'(MIX_MUL);

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

  logic [HW1-1:0] h1;
  logic [L-1:0]   h2;
  logic [HW1-1:0] h1_next;
  logic [L-1:0]   h2_next;
  logic           pend_valid;
  logic           pend_mode;
  logic [HW1-1:0] pend_h1;
  logic [L-1:0]   pend_h2;
  logic [L-1:0]   mixed;
  logic           accept;
  logic           key_end;

  assign accept   = push && !full;
  assign key_end  = empty_key || key_last;
  assign full     = pend_valid && q_status.full;
  assign job_push = pend_valid && !q_status.full;

  always_comb begin
    if (empty_key) begin
      h1_next = h1;
      h2_next = h2;
    end else begin
      h1_next = HW1'(fnv_step(64'(h1), key_byte));
      h2_next = L'(fnv_step(64'(h2), key_byte));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1         <= Off1;
      h2         <= Off2;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (key_end) begin
          h1 <= Off1;
          h2 <= Off2;
        end else begin
          h1 <= h1_next;
          h2 <= h2_next;
        end
      end
      pend_valid <= (pend_valid && !job_push) || (accept && key_end);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && key_end) begin
      pend_mode <= mode;
      pend_h1   <= h1_next;
      pend_h2   <= h2_next;
    end
  end

  assign mixed    = L'((pend_h2 ^ pend_h1[MIX_SHIFT +: L]) * MixLo) | L'(1);
  assign job_data = {pend_mode, pend_h1[L-1:0], mixed};

endmodule

// ===== src/bfdh_back.sv =====
// ----------------------------------------------------------------------------
// bfdh_back
// probe sequencer: read-modify-write of filter words and query result register
// ----------------------------------------------------------------------------
module bfdh_back import bfdh_pkg::*; #(
  parameter int NUM_PROBES  = 4,
  parameter int FILTER_BITS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  q_status_t                      q_status,
  input  logic [2*$clog2(FILTER_BITS):0] q_data,
  output logic                           q_pop,
  input  logic                           pop,
  output logic                           empty,
  output logic                           may_contain
);

  localparam int L     = $clog2(FILTER_BITS);
  localparam int Words = FILTER_BITS / WORD_BITS;
  localparam int AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int BitW  = $clog2(WORD_BITS);
  localparam int CW    = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;

  back_state_t          state;
  back_state_t          state_next;
  logic                 qmode;
  logic [L-1:0]         pos;
  logic [L-1:0]         step;
  logic [CW-1:0]        cnt;
  logic                 hit;
  logic [Words-1:0]     valid;
  logic                 out_valid;
  logic                 out_bit;
  logic                 load_out;
  logic                 ram_we;
  logic                 last_probe;
  logic [L-1:0]         pos_sh;
  logic [AW-1:0]        word;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] wr_word;
  logic                 probe_bit;

  assign pos_sh     = pos >> BitW;
  assign word       = pos_sh[AW-1:0];
  assign rd_word    = valid[word] ? ram_rdata : '0;
  assign probe_bit  = rd_word[pos[BitW-1:0]];
  assign wr_word    = rd_word | (WORD_BITS'(1) << pos[BitW-1:0]);
  assign last_probe = (cnt == CW'(NUM_PROBES - 1));

  bfdh_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (Words)
  ) u_filter_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word),
    .wdata (wr_word),
    .raddr (word),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          q_pop      = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        ram_we = (qmode == MODE_ADD);
        if (last_probe) begin
          state_next = (qmode == MODE_QUERY) ? ST_RESULT : ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_RESULT: begin
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ram_we) begin
        valid[word] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {qmode, pos, step} <= q_data;
      cnt                <= '0;
      hit                <= 1'b1;
    end else if (state == ST_UPDATE) begin
      hit <= hit & probe_bit;
      pos <= pos + step;
      cnt <= cnt + CW'(1);
    end
    if (load_out) begin
      out_bit <= hit;
    end
  end

  assign empty       = !out_valid;
  assign may_contain = out_bit;

endmodule

// ===== src/bloom_filter_256_fnv_double_hash.sv =====
// Key bytes are taken one per cycle while full is low; a key end queues a probe job in a
// two-entry queue. Each key end holds the probe unit for a filter-word read and an update
// step per probe through the filter ram, the update writing the word back only for an add;
// a query also loads its result register. Reset is synchronous; filter words read as zero
// at once through per-word valid bits, hashes return to their offset bases, no clearing pass.
// ----------------------------------------------------------------------------
// bloom_filter_256_fnv_double_hash
// streaming bloom filter with double fnv-1a hashing, decoupled hash and probe units
// ----------------------------------------------------------------------------
module bloom_filter_256_fnv_double_hash import bfdh_pkg::*; #(
  parameter int NUM_PROBES  = 4,
  parameter int FILTER_BITS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       mode,
  input  logic [7:0] key_byte,
  input  logic       key_last,
  input  logic       empty_key,
  output logic       empty,
  input  logic       pop,
  output logic       may_contain
);

  localparam int L  = $clog2(FILTER_BITS);
  localparam int JW = 1 + 2 * L;

  q_status_t       q_status;
  logic            job_push;
  logic            q_pop;
  logic [JW-1:0]   job_data;
  logic [JW-1:0]   q_data;

  bfdh_front #(
    .FILTER_BITS (FILTER_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .key_byte  (key_byte),
    .key_last  (key_last),
    .empty_key (empty_key),
    .q_status  (q_status),
    .job_push  (job_push),
    .job_data  (job_data)
  );

  bfdh_queue #(
    .WIDTH (JW),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wdata  (job_data),
    .pop    (q_pop),
    .rdata  (q_data),
    .status (q_status)
  );

  bfdh_back #(
    .NUM_PROBES  (NUM_PROBES),
    .FILTER_BITS (FILTER_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .may_contain (may_contain)
  );

endmodule

// ===== src/bfdh_checker.sv =====
// ----------------------------------------------------------------------------
// bfdh_checker
// port-level checks of the bloom filter block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfdh_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic key_last,
  input logic empty_key,
  input logic empty,
  input logic pop,
  input logic may_contain
);

  `BFDH_ASSERT_ALWAYS(a_reset_clears, rst |=> (empty && !full), "outputs not idle after reset")
  `BFDH_ASSERT(a_result_held, (!empty && !pop) |=> (!empty && $stable(may_contain)), "result lost")
  `BFDH_ASSERT(a_result_latency, $fell(empty) |-> !$past(rst, 5), "result too soon after reset")
  `BFDH_ASSERT(a_full_cause, $rose(full) |-> $past(push && (key_last || empty_key)), "full without key end")

endmodule

bind bloom_filter_256_fnv_double_hash bfdh_checker u_checker (.*);

// ===== tb/bloom_filter_256_fnv_double_hash_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bloom_filter_256_fnv_double_hash_tb
// Streams keys into the bloom filter one byte per request. Keys end by the
// last flag or by an empty-key request. A membership model predicts each
// query flag and checks it against the popped results. The sender and the
// receiver both idle at random. A long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module bloom_filter_256_fnv_double_hash_tb;
  import bfdh_pkg::*;

  localparam int          NUM_PROBES     = 4;
  localparam logic [63:0] FNV_PRIME      = 64'h100000001b3;
  localparam int          TOTAL_ITEMS    = 1150;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          DRAIN_CYCLES   = 60;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          POOL_SIZE      = 32;

  class membership_model;
    logic [255:0] filter_set;
    logic [63:0]  fnv_a;
    logic [63:0]  fnv_b;
    bit           expected_flags[$];
    int           mismatches;

    function new();
      filter_set = '0;
      fnv_a      = OFFSET_ONE;
      fnv_b      = OFFSET_TWO;
      mismatches = 0;
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    function int pending();
      return expected_flags.size();
    endfunction

    function void note_request(input logic m, input logic [7:0] b, input logic last,
                               input logic ek);
      logic [63:0] mix;
      logic [63:0] pos;
      bit          hit;
      if (!ek) begin
        fnv_a = (fnv_a ^ {56'd0, b}) * FNV_PRIME;
        fnv_b = (fnv_b ^ {56'd0, b}) * FNV_PRIME;
      end
      if (!ek && !last) return;
      mix = ((fnv_b ^ (fnv_a >> MIX_SHIFT)) * MIX_MUL) | 64'd1;
      hit = 1'b1;
      for (int k = 0; k < NUM_PROBES; k++) begin
        pos = fnv_a + 64'(k) * mix;
        if (m == MODE_ADD) filter_set[pos[7:0]] = 1'b1;
        else if (!filter_set[pos[7:0]]) hit = 1'b0;
      end
      fnv_a = OFFSET_ONE;
      fnv_b = OFFSET_TWO;
      if (m == MODE_QUERY) expected_flags.push_back(hit);
    endfunction

    task check_result(input logic got);
      bit want;
      if (expected_flags.size() == 0) begin
        report_mismatch($sformatf("may_contain %0b with no query waiting", got));
        return;
      end
      want = expected_flags.pop_front();
      if (got !== want)
        report_mismatch($sformatf("may_contain got %0b expected %0b", got, want));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic       mode;
  logic [7:0] key_byte;
  logic       key_last;
  logic       empty_key;
  logic       empty;
  logic       pop;
  logic       may_contain;

  membership_model sb;
  int         send_idle_pct = 19;
  int         recv_idle_pct = 85;
  int         stim_phase    = 0;
  int         items_sent    = 0;
  int         quiet_cycles  = 0;
  bit         held          = 1'b0;
  logic [7:0] key_buf [8];
  int         key_len;
  logic [7:0] pool_bytes [POOL_SIZE][8];
  int         pool_len [POOL_SIZE];
  int         pool_cnt = 0;

  bloom_filter_256_fnv_double_hash dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .key_byte   (key_byte),
    .key_last   (key_last),
    .empty_key  (empty_key),
    .empty      (empty),
    .pop        (pop),
    .may_contain(may_contain)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    mode      = 1'b0;
    key_byte  = 8'd0;
    key_last  = 1'b0;
    empty_key = 1'b0;
    pop       = 1'b0;
    sb        = new();
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_request(mode, key_byte, key_last, empty_key);
      if (pop && !empty) sb.check_result(may_contain);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL bloom_filter_256_fnv_double_hash");
        $finish;
      end
    end
  end

  // receiver, with one long hold-off when full-rate streaming starts
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stim_phase == 2 && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic m, input logic [7:0] b, input logic last,
                           input logic ek);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    mode      <= m;
    key_byte  <= b;
    key_last  <= last;
    empty_key <= ek;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // sends key_buf; the key ends on its final byte or by a trailing empty-key request
  task automatic send_key(input logic m, input bit by_empty);
    bit final_byte;
    for (int j = 0; j < key_len; j++) begin
      final_byte = (j == key_len - 1) && !by_empty;
      send_item(final_byte ? m : 1'($urandom_range(1)), key_buf[j], final_byte, 1'b0);
    end
    if (by_empty || key_len == 0)
      send_item(m, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic make_key();
    bit narrow;
    narrow = ($urandom_range(4) == 0);
    if ($urandom_range(19) == 0) key_len = 0;
    else if ($urandom_range(9) == 0) key_len = $urandom_range(8, 1);
    else key_len = $urandom_range(4, 1);
    for (int j = 0; j < key_len; j++)
      key_buf[j] = narrow ? 8'($urandom_range(3)) : 8'($urandom_range(255));
  endtask

  initial begin
    int roll;
    int slot;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero-length key against an empty filter, then inserted
    send_item(MODE_QUERY, 8'h00, 1'b1, 1'b1);
    send_item(MODE_ADD,   8'hff, 1'b0, 1'b1);
    send_item(MODE_QUERY, 8'hff, 1'b0, 1'b1);
    // two-byte key, mode ignored on the non-final byte
    send_item(MODE_QUERY, 8'h00, 1'b0, 1'b0);
    send_item(MODE_ADD,   8'hff, 1'b1, 1'b0);
    send_item(MODE_ADD,   8'h00, 1'b0, 1'b0);
    send_item(MODE_QUERY, 8'hff, 1'b1, 1'b0);
    // same key ended by both flags on a third request
    send_item(MODE_ADD,   8'h00, 1'b0, 1'b0);
    send_item(MODE_QUERY, 8'hff, 1'b0, 1'b0);
    send_item(MODE_QUERY, 8'ha5, 1'b1, 1'b1);
    // empty-key requests ending one-byte keys mid-stream
    send_item(MODE_QUERY, 8'h5a, 1'b0, 1'b0);
    send_item(MODE_QUERY, 8'h33, 1'b0, 1'b1);
    send_item(MODE_ADD,   8'h5a, 1'b0, 1'b0);
    send_item(MODE_ADD,   8'hcc, 1'b0, 1'b1);
    send_item(MODE_QUERY, 8'h5a, 1'b1, 1'b0);
    send_item(MODE_QUERY, 8'h00, 1'b1, 1'b0);
    send_item(MODE_ADD,   8'hff, 1'b1, 1'b0);
    send_item(MODE_QUERY, 8'hff, 1'b1, 1'b0);
    send_item(MODE_QUERY, 8'h80, 1'b1, 1'b0);

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= 770) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stim_phase    = 2;
      end else if (items_sent >= 400) begin
        send_idle_pct = 85;
        recv_idle_pct = 19;
        stim_phase    = 1;
      end
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else if (roll < 20) begin
        make_key();
        slot = (pool_cnt < POOL_SIZE) ? pool_cnt : $urandom_range(POOL_SIZE - 1);
        if (pool_cnt < POOL_SIZE) pool_cnt++;
        pool_len[slot] = key_len;
        for (int j = 0; j < 8; j++) pool_bytes[slot][j] = key_buf[j];
        send_key(MODE_ADD, $urandom_range(3) == 0);
      end else if (roll < 60 && pool_cnt > 0) begin
        slot = $urandom_range(pool_cnt - 1);
        key_len = pool_len[slot];
        for (int j = 0; j < 8; j++) key_buf[j] = pool_bytes[slot][j];
        send_key(MODE_QUERY, $urandom_range(3) == 0);
      end else begin
        make_key();
        send_key(MODE_QUERY, $urandom_range(3) == 0);
      end
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS bloom_filter_256_fnv_double_hash");
    end else begin
      $display("FAIL bloom_filter_256_fnv_double_hash");
    end
    $finish;
  end

endmodule
